FILE: rtl/clt_pkg.sv
// Shared types, character codes and a helper function of the command line tokenizer.
package clt_pkg;

  localparam int unsigned PARAM_LEN_W = 6;
  localparam int unsigned CMD_LEN_W   = 3;
  localparam int unsigned CMD_MAX     = 4;

  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_SLASH  = 8'h2F;
  localparam logic [7:0] CHAR_BSLASH = 8'h5C;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_LOW_A  = 8'h61;
  localparam logic [7:0] CHAR_LOW_Z  = 8'h7A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  typedef enum logic [2:0] {
    KIND_EMPTY    = 3'd0,
    KIND_HEADER   = 3'd1,
    KIND_PARAM    = 3'd2,
    KIND_LONG_LINE = 3'd3,
    KIND_LONG_CMD = 3'd4
  } kind_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  store;
    logic  clear;
    logic  emit;
    kind_e kind;
    logic  rd_start;
    logic  rd_next;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic is_cr;
    logic is_lf;
    logic full;
    logic empty;
    logic cmd_long;
    logic plen_zero;
    logic rd_last;
  } dp_status_t;

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CHAR_LOW_A && c <= CHAR_LOW_Z) begin
      r = c - CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

FILE: rtl/clt_ifs.sv
// Valid/ready channel interfaces for received bytes and for tokenizer results.
interface clt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface clt_out_if;
  logic                                valid;
  logic                                ready;
  logic [2:0]                          kind;
  logic [31:0]                         cmd_word;
  logic [clt_pkg::CMD_LEN_W-1:0]       cmd_len;
  logic [clt_pkg::PARAM_LEN_W-1:0]     param_len;
  logic [7:0]                          param_byte;
  logic                                last;

  modport source (output valid, output kind, output cmd_word, output cmd_len,
                  output param_len, output param_byte, output last, input ready);
  modport sink (input valid, input kind, input cmd_word, input cmd_len,
                input param_len, input param_byte, input last, output ready);
endinterface

FILE: rtl/clt_datapath.sv
// Datapath: line store memory, line bookkeeping, command capture and the output register.
module clt_datapath #(
  parameter int unsigned LINE_CAP = 48
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [7:0]                      rx_byte_i,
  input  logic                            out_ready_i,
  input  clt_pkg::ctrl_cmd_t              cmd_i,
  output clt_pkg::dp_status_t             status_o,
  output logic                            out_valid_o,
  output logic [2:0]                      kind_o,
  output logic [31:0]                     cmd_word_o,
  output logic [clt_pkg::CMD_LEN_W-1:0]   cmd_len_o,
  output logic [clt_pkg::PARAM_LEN_W-1:0] param_len_o,
  output logic [7:0]                      param_byte_o,
  output logic                            last_o
);

  localparam int unsigned CntW = $clog2(LINE_CAP + 1);
  localparam int unsigned IdxW = $clog2(LINE_CAP);

  logic [7:0]      mem [LINE_CAP];
  logic [7:0]      rdata_q;
  logic [7:0]      cmd_b_q [clt_pkg::CMD_MAX];
  logic [CntW-1:0] fill_q, space_pos_q, start_q, rd_ptr_q;
  logic            space_seen_q, found_q;

  logic [7:0]      c;
  logic [CntW-1:0] clen, plen;
  logic [31:0]     word;
  logic            out_valid_q;

  always_comb begin
    c = (rx_byte_i == clt_pkg::CHAR_BSLASH) ? clt_pkg::CHAR_SLASH : rx_byte_i;
    clen = space_seen_q ? space_pos_q : fill_q;
    plen = found_q ? (fill_q - start_q) : '0;
    word = '0;
    for (int i = 0; i < clt_pkg::CMD_MAX; i++) begin
      if (CntW'(i) < clen) begin
        word[31-8*i -: 8] = clt_pkg::to_upper(cmd_b_q[i]);
      end
    end
  end

  always_comb begin
    status_o.out_free  = !out_valid_q || out_ready_i;
    status_o.is_cr     = (c == clt_pkg::CHAR_CR);
    status_o.is_lf     = (c == clt_pkg::CHAR_LF);
    status_o.full      = (fill_q == CntW'(LINE_CAP));
    status_o.empty     = (fill_q == '0);
    status_o.cmd_long  = (clen > CntW'(clt_pkg::CMD_MAX));
    status_o.plen_zero = !found_q;
    status_o.rd_last   = ((rd_ptr_q + CntW'(1)) == fill_q);
  end

  // Line store: written at the fill pointer, read at the readout pointer.
  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      mem[fill_q[IdxW-1:0]] <= c;
    end
    rdata_q <= mem[rd_ptr_q[IdxW-1:0]];
  end

  // The first command bytes are kept in flops so the header is formed at once.
  always_ff @(posedge clk_i) begin
    if (cmd_i.store && fill_q < CntW'(clt_pkg::CMD_MAX)) begin
      cmd_b_q[fill_q[1:0]] <= c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q       <= '0;
      space_pos_q  <= '0;
      space_seen_q <= 1'b0;
      found_q      <= 1'b0;
      start_q      <= '0;
      rd_ptr_q     <= '0;
    end else begin
      if (cmd_i.clear) begin
        fill_q       <= '0;
        space_pos_q  <= '0;
        space_seen_q <= 1'b0;
        found_q      <= 1'b0;
        start_q      <= '0;
      end else if (cmd_i.store) begin
        fill_q <= fill_q + CntW'(1);
        if (c == clt_pkg::CHAR_SPACE && !space_seen_q) begin
          space_seen_q <= 1'b1;
          space_pos_q  <= fill_q;
        end else if (space_seen_q && !found_q && c != clt_pkg::CHAR_SPACE) begin
          // First non-space after the command separator opens the parameter.
          found_q <= 1'b1;
          start_q <= fill_q;
        end
      end
      if (cmd_i.rd_start) begin
        rd_ptr_q <= start_q;
      end else if (cmd_i.rd_next) begin
        rd_ptr_q <= rd_ptr_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      kind_o       <= cmd_i.kind;
      cmd_word_o   <= '0;
      cmd_len_o    <= '0;
      param_len_o  <= '0;
      param_byte_o <= '0;
      last_o       <= 1'b1;
      case (cmd_i.kind)
        clt_pkg::KIND_HEADER: begin
          cmd_word_o  <= word;
          cmd_len_o   <= clt_pkg::CMD_LEN_W'(clen);
          param_len_o <= clt_pkg::PARAM_LEN_W'(plen);
          last_o      <= !found_q;
        end
        clt_pkg::KIND_PARAM: begin
          param_byte_o <= rdata_q;
          last_o       <= status_o.rd_last;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

  a_emit_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over an untaken result");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(LINE_CAP))
    else $error("fill count beyond line capacity");

  a_read_in_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_next |-> (rd_ptr_q < fill_q))
    else $error("readout beyond stored bytes");

  a_no_store_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.store |-> (fill_q < CntW'(LINE_CAP)))
    else $error("store into a full line");

endmodule

FILE: rtl/clt_ctrl.sv
// Controller: classifies each accepted byte and sequences the parameter readout.
module clt_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  clt_pkg::dp_status_t  status_i,
  output clt_pkg::ctrl_cmd_t   cmd_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FETCH = 2'd1;
  localparam logic [1:0] ST_EMIT  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == ST_IDLE) && status_i.out_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.kind = clt_pkg::KIND_EMPTY;
    case (state_q)
      ST_IDLE: begin
        if (accept && !status_i.is_cr) begin
          if (!status_i.is_lf) begin
            if (!status_i.full) begin
              cmd_o.store = 1'b1;
            end else begin
              cmd_o.clear = 1'b1;
              cmd_o.emit  = 1'b1;
              cmd_o.kind  = clt_pkg::KIND_LONG_LINE;
            end
          end else if (status_i.empty) begin
            cmd_o.emit = 1'b1;
            cmd_o.kind = clt_pkg::KIND_EMPTY;
          end else if (status_i.cmd_long) begin
            cmd_o.clear = 1'b1;
            cmd_o.emit  = 1'b1;
            cmd_o.kind  = clt_pkg::KIND_LONG_CMD;
          end else begin
            cmd_o.emit = 1'b1;
            cmd_o.kind = clt_pkg::KIND_HEADER;
            if (status_i.plen_zero) begin
              cmd_o.clear = 1'b1;
            end else begin
              cmd_o.rd_start = 1'b1;
              state_d        = ST_FETCH;
            end
          end
        end
      end
      ST_FETCH: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit    = 1'b1;
          cmd_o.kind    = clt_pkg::KIND_PARAM;
          cmd_o.rd_next = 1'b1;
          if (status_i.rd_last) begin
            cmd_o.clear = 1'b1;
            state_d     = ST_IDLE;
          end else begin
            state_d = ST_FETCH;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_fetch_then_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FETCH) |=> (state_q == ST_EMIT))
    else $error("fetch not followed by emit");

  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !in_ready_o)
    else $error("byte accepted during readout");

  a_store_or_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.store && cmd_o.emit))
    else $error("store and emit in the same cycle");

endmodule

FILE: rtl/command_line_tokenizer.sv
// Top level of the command line tokenizer: controller plus datapath on two channels.
//
// The tokenizer takes received control-channel characters, one per input
// transaction, and collects them into a line store of LINE_CAP bytes. A
// backslash is stored as a forward slash and a carriage return is dropped.
// A line feed ends the line: the line is split at its first space, the
// command (at most four characters) is uppercased and packed into cmd_word
// with its first character in the top byte, and spaces after it are
// skipped. The block then delivers a header transaction followed by one
// transaction per parameter byte, the final one flagged by last. An empty
// line, an overlong line (a byte arriving with the store full) and an
// overlong command each give a single transaction of their own kind. An
// ordinary byte or a carriage return is taken and gives no result. The
// first result of a line feed is ready the next cycle; while parameter
// bytes are read out no input transaction is accepted, and each parameter
// byte is first read from the line store's single registered read port and
// then loaded into the output register. A line with parameter bytes
// therefore holds the input off until its last parameter byte is taken.
// No byte is accepted while a result waits in the output register; a new
// byte can be accepted in the same cycle in which the previous result is
// taken. The line store has no reset; only bytes written in the current
// line are ever read back.
module command_line_tokenizer #(
  parameter int unsigned LINE_CAP = 48
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  clt_in_if.sink       in_if,
  clt_out_if.source    out_if
);

  clt_pkg::ctrl_cmd_t  cmd;
  clt_pkg::dp_status_t status;
  logic                in_ready;

  // The controller decides what each accepted byte does.
  clt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath holds the line and drives the result channel.
  clt_datapath #(
    .LINE_CAP (LINE_CAP)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_byte_i    (in_if.rx_byte),
    .out_ready_i  (out_if.ready),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (out_if.valid),
    .kind_o       (out_if.kind),
    .cmd_word_o   (out_if.cmd_word),
    .cmd_len_o    (out_if.cmd_len),
    .param_len_o  (out_if.param_len),
    .param_byte_o (out_if.param_byte),
    .last_o       (out_if.last)
  );

  assign in_if.ready = in_ready;

  // A result is only ever loaded when the output register is free.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && !out_if.ready) |=> $stable(out_if.cmd_word))
    else $error("pending result changed while stalled");

  // A line feed that produces a header makes the header visible next cycle.
  a_result_follows_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |=> out_if.valid)
    else $error("emitted result not presented");

  // Readout holds the input side off.
  a_readout_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rd_start |=> !in_if.ready)
    else $error("input accepted at start of readout");

endmodule

FILE: verif/command_line_tokenizer_tb.sv
// Self-checking testbench for the command line tokenizer with a line predictor.
`timescale 1ns / 1ps

module command_line_tokenizer_tb;

  localparam int unsigned LINE_CAP = 48;
  localparam int unsigned RANDOM_BYTES = 320;
  localparam int unsigned DRAIN_CYCLES = 20;

  // One result transaction as seen on the output channel.
  typedef struct {
    logic [2:0]                      kind;
    logic [31:0]                     cmd_word;
    logic [clt_pkg::CMD_LEN_W-1:0]   cmd_len;
    logic [clt_pkg::PARAM_LEN_W-1:0] param_len;
    logic [7:0]                      param_byte;
    logic                            last;
  } token_t;

  // The scoreboard keeps its own copy of the line store and predicts the
  // tokens that each accepted byte produces. Tokens are checked in order.
  class token_checker;
    logic [7:0]  line_buf [LINE_CAP];
    int unsigned fill = 0;
    int unsigned space_at = 0;
    bit          space_found = 1'b0;
    token_t      tokens_due [$];
    int unsigned mismatches = 0;

    function void restart_line();
      fill = 0;
      space_at = 0;
      space_found = 1'b0;
    endfunction

    function void queue_token(clt_pkg::kind_e kind, logic [31:0] word, int unsigned clen,
                              int unsigned plen, logic [7:0] pbyte, bit last);
      token_t t;
      t.kind       = kind;
      t.cmd_word   = word;
      t.cmd_len    = clen[clt_pkg::CMD_LEN_W-1:0];
      t.param_len  = plen[clt_pkg::PARAM_LEN_W-1:0];
      t.param_byte = pbyte;
      t.last       = last;
      tokens_due.push_back(t);
    endfunction

    // Called once for every accepted input transaction.
    function void take_byte(logic [7:0] b);
      logic [7:0]  c;
      logic [7:0]  ch;
      logic [31:0] word;
      int unsigned clen;
      int unsigned start;
      c = (b == clt_pkg::CHAR_BSLASH) ? clt_pkg::CHAR_SLASH : b;
      if (c == clt_pkg::CHAR_CR) return;
      if (c != clt_pkg::CHAR_LF) begin
        if (fill < LINE_CAP) begin
          if (c == clt_pkg::CHAR_SPACE && !space_found) begin
            space_found = 1'b1;
            space_at = fill;
          end
          line_buf[fill] = c;
          fill++;
        end else begin
          // The byte that finds the store full is dropped with the line.
          restart_line();
          queue_token(clt_pkg::KIND_LONG_LINE, '0, 0, 0, '0, 1'b1);
        end
        return;
      end
      if (fill == 0) begin
        queue_token(clt_pkg::KIND_EMPTY, '0, 0, 0, '0, 1'b1);
        return;
      end
      clen = space_found ? space_at : fill;
      if (clen > clt_pkg::CMD_MAX) begin
        restart_line();
        queue_token(clt_pkg::KIND_LONG_CMD, '0, 0, 0, '0, 1'b1);
        return;
      end
      word = '0;
      for (int i = 0; i < clen; i++) begin
        ch = line_buf[i];
        if (ch >= clt_pkg::CHAR_LOW_A && ch <= clt_pkg::CHAR_LOW_Z)
          ch = ch - clt_pkg::CASE_OFFSET;
        word[31 - 8 * i -: 8] = ch;
      end
      // Spaces right after the command are skipped, all later ones kept.
      start = fill;
      if (space_found) begin
        start = space_at + 1;
        while (start < fill && line_buf[start] == clt_pkg::CHAR_SPACE) start++;
      end
      queue_token(clt_pkg::KIND_HEADER, word, clen, fill - start, '0, fill == start);
      for (int unsigned i = start; i < fill; i++) begin
        queue_token(clt_pkg::KIND_PARAM, '0, 0, 0, line_buf[i], i + 1 == fill);
      end
      restart_line();
    endfunction

    task flag_mismatch(string msg);
      if (mismatches < 200) $display("%0t mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_token(token_t got);
      token_t want;
      string  diff;
      if (tokens_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected result, kind %0d", got.kind));
        return;
      end
      want = tokens_due.pop_front();
      diff = "";
      if (got.kind !== want.kind)
        diff = {diff, $sformatf(" kind %0d/%0d", got.kind, want.kind)};
      if (got.cmd_word !== want.cmd_word)
        diff = {diff, $sformatf(" cmd_word %h/%h", got.cmd_word, want.cmd_word)};
      if (got.cmd_len !== want.cmd_len)
        diff = {diff, $sformatf(" cmd_len %0d/%0d", got.cmd_len, want.cmd_len)};
      if (got.param_len !== want.param_len)
        diff = {diff, $sformatf(" param_len %0d/%0d", got.param_len, want.param_len)};
      if (got.param_byte !== want.param_byte)
        diff = {diff, $sformatf(" param_byte %h/%h", got.param_byte, want.param_byte)};
      if (got.last !== want.last)
        diff = {diff, $sformatf(" last %b/%b", got.last, want.last)};
      if (diff != "") flag_mismatch({"result fields differ (got/want):", diff});
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  clt_in_if  in_ch ();
  clt_out_if out_ch ();

  command_line_tokenizer #(
    .LINE_CAP(LINE_CAP)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (in_ch),
    .out_if(out_ch)
  );

  token_checker board = new();

  // When calm is set, neither the sender nor the receiver inserts idle
  // cycles, so some lines run back to back at full rate.
  bit          calm = 1'b0;
  int unsigned bytes_sent = 0;
  logic [7:0]  line_q [$];

  initial clk_i = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mostly no gap, often a short one and now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // A text byte never is a line feed or carriage return. Command bytes are
  // never spaces and are letters of either case half of the time.
  function automatic logic [7:0] text_char(bit for_cmd);
    logic [7:0] c;
    if (for_cmd && $urandom_range(0, 1)) begin
      c = 8'($urandom_range(0, 25));
      c = c + ($urandom_range(0, 1) ? clt_pkg::CHAR_LOW_A
                                    : clt_pkg::CHAR_LOW_A - clt_pkg::CASE_OFFSET);
      return c;
    end
    do begin
      c = 8'($urandom_range(0, 255));
    end while (c == clt_pkg::CHAR_LF || c == clt_pkg::CHAR_CR ||
               (for_cmd && c == clt_pkg::CHAR_SPACE));
    return c;
  endfunction

  // Sends one byte. The task is entered at a rising edge. valid is only
  // lowered when a gap is inserted, so with no gap it simply stays high and
  // the next byte is presented in the cycle after the previous transaction.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    board.take_byte(b);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Sends the bytes of line_q, with a stray carriage return now and then.
  task automatic send_line();
    foreach (line_q[k]) begin
      if ($urandom_range(0, 19) == 0) send_byte(clt_pkg::CHAR_CR);
      send_byte(line_q[k]);
    end
  endtask

  // Holds the input idle until every predicted token has been delivered.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (board.tokens_due.size() != 0) @(posedge clk_i);
  endtask

  // Receiver side: checks each result transaction and throttles ready.
  initial begin : result_side
    token_t      got;
    int unsigned stall_left;
    out_ch.ready = 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_ch.valid && out_ch.ready) begin
        got.kind       = out_ch.kind;
        got.cmd_word   = out_ch.cmd_word;
        got.cmd_len    = out_ch.cmd_len;
        got.param_len  = out_ch.param_len;
        got.param_byte = out_ch.param_byte;
        got.last       = out_ch.last;
        board.check_token(got);
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // Stimulus: a handful of directed lines, then random lines until enough
  // bytes have gone in, then a drain and the verdict.
  initial begin : byte_side
    int unsigned r;
    int unsigned clen;
    int unsigned nsp;
    int unsigned plen;
    int unsigned base;
    rst_ni        = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = 8'h00;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // An empty line.
    send_byte(clt_pkg::CHAR_LF);
    // A backslash in the command, zero and all-ones bytes in the parameter,
    // and a carriage return that must vanish.
    send_text("ab\\ ");
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(clt_pkg::CHAR_CR);
    send_byte(clt_pkg::CHAR_LF);
    // A leading space gives an empty command; the extra space is skipped
    // and the trailing one is kept.
    send_text("  x ");
    send_byte(clt_pkg::CHAR_LF);
    // A full four-letter lowercase command with no parameter.
    send_text("quit");
    send_byte(clt_pkg::CHAR_LF);
    // A command one byte too long.
    send_text("abcde f");
    send_byte(clt_pkg::CHAR_LF);

    // Let every directed token out before the random part starts.
    wait_drained();

    base = bytes_sent;
    while (bytes_sent < base + RANDOM_BYTES) begin
      calm = ($urandom_range(0, 6) == 0);
      line_q.delete();
      r = $urandom_range(0, 99);
      if (r < 65) begin
        // Well-formed command line, sometimes filled to the last store slot.
        clen = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, clt_pkg::CMD_MAX);
        for (int i = 0; i < clen; i++) line_q.push_back(text_char(1'b1));
        nsp = (clen == 0) ? $urandom_range(1, 3) : $urandom_range(0, 3);
        for (int i = 0; i < nsp; i++) line_q.push_back(clt_pkg::CHAR_SPACE);
        if (nsp > 0) begin
          if ($urandom_range(0, 9) == 0) begin
            plen = LINE_CAP - clen - nsp;
          end else begin
            plen = $urandom_range(0, 12);
          end
          for (int i = 0; i < plen; i++) line_q.push_back(text_char(1'b0));
        end
        line_q.push_back(clt_pkg::CHAR_LF);
      end else if (r < 77) begin
        // Command too long, with or without a parameter.
        clen = $urandom_range(clt_pkg::CMD_MAX + 1, 10);
        for (int i = 0; i < clen; i++) line_q.push_back(text_char(1'b1));
        if ($urandom_range(0, 1)) begin
          line_q.push_back(clt_pkg::CHAR_SPACE);
          plen = $urandom_range(0, 5);
          for (int i = 0; i < plen; i++) line_q.push_back(text_char(1'b0));
        end
        line_q.push_back(clt_pkg::CHAR_LF);
      end else if (r < 87) begin
        // Overflow of the store; the bytes after the dropped one begin a
        // new line that the line feed then ends.
        plen = $urandom_range(LINE_CAP + 1, LINE_CAP + 4);
        for (int i = 0; i < plen; i++) line_q.push_back(text_char(1'b0));
        line_q.push_back(clt_pkg::CHAR_LF);
      end else if (r < 93) begin
        line_q.push_back(clt_pkg::CHAR_LF);
      end else begin
        // Raw noise, any byte value at all.
        plen = $urandom_range(1, 8);
        for (int i = 0; i < plen; i++) line_q.push_back(8'($urandom_range(0, 255)));
      end
      send_line();
    end

    calm = 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.tokens_due.size() != 0)
      board.flag_mismatch($sformatf("%0d results never arrived", board.tokens_due.size()));
    if (board.mismatches == 0) begin
      $display("[command_line_tokenizer] OK");
    end else begin
      $display("[command_line_tokenizer] ERROR");
    end
    $finish;
  end

  // Guard against a hung handshake: far beyond the slowest legal run.
  initial begin : watchdog
    #20_000_000;
    $display("[command_line_tokenizer] ERROR");
    $finish;
  end

endmodule
